// File: rtl/klerp_pkg.sv
// Shared types, constants and the command and status structs for the keyframe lerp sampler.
package klerp_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int FRAC_W = 16;
   localparam int NUM_CH = 5;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_SAMPLE = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_ORDER = 2'd3;

   typedef logic signed [DATA_W-1:0] word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load_req;    // capture the input item
      logic             write_key;   // write the captured item at key_count
      logic             rd_en;       // issue a read of the memory
      logic [IDX_W-1:0] rd_addr;
      logic             cap_left;    // registered read data is the left key
      logic             cap_right;   // registered read data is the right key
      logic             div_start;
      logic             lerp_step;   // one channel multiply
      logic             zero_out;
      logic             copy_out;    // result is the left key as is
      logic             lerp_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       stamp_le;    // read stamp at or below query time
      logic       order_bad;   // append stamp below read stamp
      logic       span_pos;    // right stamp above left stamp
      logic       div_done;
   } stat_type;

endpackage

// File: rtl/klerp_datapath.sv
// Keyframe memory, restoring divider and shared lerp multiplier.
module klerp_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  klerp_pkg::cmd_type     cmd,
   output klerp_pkg::stat_type    stat,
   input  logic [klerp_pkg::IDX_W-1:0] wr_addr,
   input  logic [1:0]             req_op,
   input  klerp_pkg::word_type    req_time_req,
   input  klerp_pkg::word_type    req_pos_x,
   input  klerp_pkg::word_type    req_pos_y,
   input  klerp_pkg::word_type    req_orientation,
   input  klerp_pkg::word_type    req_scale_x,
   input  klerp_pkg::word_type    req_scale_y,
   output klerp_pkg::word_type    res_ch [klerp_pkg::NUM_CH]
);

   localparam int KW = klerp_pkg::DATA_W * (klerp_pkg::NUM_CH + 1);
   localparam int DW = klerp_pkg::DATA_W;
   localparam int FW = klerp_pkg::FRAC_W;

   logic [KW-1:0] mem [klerp_pkg::DEPTH];
   logic [KW-1:0] rd_ff;
   logic [1:0] op_ff;
   klerp_pkg::word_type q_ff;
   logic [KW-1:0] item_ff;
   logic [KW-1:0] left_ff, right_ff;
   logic [2:0] ch_ff, ch_in;

   // Divider: quotient of (q-L)<<16 by (R-L), 17 bits then saturated.
   logic [DW:0] span_ff;
   logic [DW+1:0] rem_ff, rem_in, trial;
   logic [DW+FW:0] num_ff, num_in;
   logic [FW:0] quo_ff, quo_in;
   logic [5:0] dcnt_ff, dcnt_in;
   logic busy_ff, busy_in;
   logic [FW-1:0] t_val;

   always_ff @(posedge clock) begin
      if (cmd.write_key) begin
         mem[wr_addr] <= item_ff;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_op;
         q_ff <= req_time_req;
         item_ff <= {req_scale_y, req_scale_x, req_orientation, req_pos_y, req_pos_x,
                     req_time_req};
      end
      if (cmd.cap_left) begin
         left_ff <= rd_ff;
      end
      if (cmd.cap_right) begin
         right_ff <= rd_ff;
      end
   end

   logic signed [DW:0] rd_stamp, q_ext, l_stamp, r_stamp;
   assign rd_stamp = {rd_ff[DW-1], rd_ff[DW-1:0]};
   assign q_ext = {q_ff[DW-1], q_ff};
   assign l_stamp = {left_ff[DW-1], left_ff[DW-1:0]};
   assign r_stamp = {right_ff[DW-1], right_ff[DW-1:0]};

   assign stat.op = op_ff;
   assign stat.stamp_le = rd_stamp <= q_ext;
   assign stat.order_bad = q_ext < rd_stamp;
   assign stat.span_pos = r_stamp > l_stamp;
   assign stat.div_done = !busy_ff;

   always_comb begin
      busy_in = busy_ff;
      dcnt_in = dcnt_ff;
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      trial = {rem_ff[DW:0], num_ff[DW+FW]} - {1'b0, span_ff};
      if (cmd.div_start) begin
         busy_in = 1'b1;
         dcnt_in = 6'(DW + FW + 1);
         rem_in = '0;
         num_in = {(DW + 1)'(q_ext - l_stamp), {FW{1'b0}}};
         quo_in = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[DW+FW-1:0], 1'b0};
         if (!trial[DW+1]) begin
            rem_in = trial;
            quo_in = {quo_ff[FW-1:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DW:0], num_ff[DW+FW]};
            quo_in = {quo_ff[FW-1:0], 1'b0};
         end
         dcnt_in = dcnt_ff - 6'd1;
         if (dcnt_ff == 6'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      dcnt_ff <= dcnt_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      if (cmd.div_start) begin
         span_ff <= (DW + 1)'(r_stamp - l_stamp);
      end
   end

   // The quotient can reach 65536 only at the bound, so it saturates.
   assign t_val = quo_ff[FW] ? {FW{1'b1}} : quo_ff[FW-1:0];

   // One channel a step: product registered, then added to the left value.
   logic signed [DW:0] diff;
   logic signed [DW+FW+1:0] prod_ff;
   logic [2:0] pch_ff;
   logic pv_ff;
   klerp_pkg::word_type lerp_ff [klerp_pkg::NUM_CH];
   klerp_pkg::word_type a_sel, b_sel;

   always_comb begin
      a_sel = left_ff[DW*(ch_ff+1) +: DW];
      b_sel = right_ff[DW*(ch_ff+1) +: DW];
      diff = {b_sel[DW-1], b_sel} - {a_sel[DW-1], a_sel};
      ch_in = cmd.lerp_step ? ch_ff + 3'd1 : (cmd.div_start ? 3'd0 : ch_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         ch_ff <= '0;
      end else begin
         pv_ff <= cmd.lerp_step;
         ch_ff <= ch_in;
      end
      prod_ff <= diff * $signed({1'b0, t_val});
      pch_ff <= ch_ff;
      if (pv_ff) begin
         lerp_ff[pch_ff] <= DW'($signed(left_ff[DW*(pch_ff+1) +: DW])
                           + (prod_ff >>> FW));
      end
   end

   always_comb begin
      for (int i = 0; i < klerp_pkg::NUM_CH; i++) begin
         if (cmd.lerp_out) begin
            res_ch[i] = lerp_ff[i];
         end else if (cmd.copy_out) begin
            res_ch[i] = left_ff[DW*(i+1) +: DW];
         end else begin
            res_ch[i] = '0;
         end
      end
   end

endmodule

// File: rtl/klerp_ctrl.sv
// Sequencer for clear, append and sample, with the load strobe for the output register.
module klerp_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output klerp_pkg::cmd_type          cmd,
   input  klerp_pkg::stat_type         stat,
   output logic [klerp_pkg::IDX_W-1:0] wr_addr,
   output logic                        out_load
);

   typedef enum logic [3:0] {
      IDLE, DECODE, APP_CHK, SRCH_RD, SRCH_CMP, LD_LEFT, LD_RIGHT,
      CAP_R, DIVIDE, LERP, LERP_END, FINISH, RESPOND
   } state_type;

   localparam int IW = klerp_pkg::IDX_W;
   localparam int CW = klerp_pkg::CNT_W;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, ub_ff, ub_in;
   logic [1:0] status_ff, status_in;
   logic [2:0] step_ff, step_in;
   logic [1:0] kind_ff, kind_in;   // 0 zero, 1 copy, 2 lerp
   logic [CW:0] mid_sum;
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};

   assign req_ready = state_ff == IDLE;
   assign rsp_valid = state_ff == RESPOND;
   assign rsp_status = status_ff;
   assign wr_addr = count_ff[IW-1:0];

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      ub_in = ub_ff;
      status_in = status_ff;
      step_in = step_ff;
      kind_in = kind_ff;
      cmd = '0;
      out_load = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = DECODE;
            end
         end
         DECODE: begin
            status_in = klerp_pkg::ST_OK;
            kind_in = 2'd0;
            case (stat.op)
               klerp_pkg::OP_CLEAR: begin
                  count_in = '0;
                  state_in = FINISH;
               end
               klerp_pkg::OP_APPEND: begin
                  if (count_ff == CW'(klerp_pkg::DEPTH)) begin
                     status_in = klerp_pkg::ST_FULL;
                     state_in = FINISH;
                  end else if (count_ff == '0) begin
                     cmd.write_key = 1'b1;
                     count_in = count_ff + 1'b1;
                     state_in = FINISH;
                  end else begin
                     cmd.rd_en = 1'b1;
                     cmd.rd_addr = IW'(count_ff - 1'b1);
                     state_in = APP_CHK;
                  end
               end
               klerp_pkg::OP_SAMPLE: begin
                  if (count_ff == '0) begin
                     status_in = klerp_pkg::ST_EMPTY;
                     state_in = FINISH;
                  end else begin
                     lo_in = '0;
                     hi_in = count_ff;
                     state_in = SRCH_RD;
                  end
               end
               default: state_in = FINISH;
            endcase
         end
         APP_CHK: begin
            if (stat.order_bad) begin
               status_in = klerp_pkg::ST_ORDER;
            end else begin
               cmd.write_key = 1'b1;
               count_in = count_ff + 1'b1;
            end
            state_in = FINISH;
         end
         SRCH_RD: begin
            // Upper bound: first index in [lo, hi) whose stamp exceeds q.
            if (lo_ff == hi_ff) begin
               ub_in = lo_ff;
               cmd.rd_en = 1'b1;
               cmd.rd_addr = (lo_ff == '0) ? '0 : IW'(lo_ff - 1'b1);
               state_in = LD_LEFT;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_addr = IW'(mid_sum >> 1);
               state_in = SRCH_CMP;
            end
         end
         SRCH_CMP: begin
            if (stat.stamp_le) begin
               lo_in = CW'(mid_sum >> 1) + CW'(1);
            end else begin
               hi_in = CW'(mid_sum >> 1);
            end
            state_in = SRCH_RD;
         end
         LD_LEFT: begin
            cmd.cap_left = 1'b1;
            if (ub_ff == '0 || ub_ff == count_ff) begin
               kind_in = 2'd1;
               state_in = FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               cmd.rd_addr = IW'(ub_ff);
               state_in = LD_RIGHT;
            end
         end
         LD_RIGHT: begin
            cmd.cap_right = 1'b1;
            state_in = CAP_R;
         end
         CAP_R: begin
            if (stat.span_pos) begin
               cmd.div_start = 1'b1;
               state_in = DIVIDE;
            end else begin
               kind_in = 2'd1;
               state_in = FINISH;
            end
         end
         DIVIDE: begin
            if (stat.div_done) begin
               step_in = '0;
               state_in = LERP;
            end
         end
         LERP: begin
            cmd.lerp_step = 1'b1;
            step_in = step_ff + 3'd1;
            if (step_ff == 3'(klerp_pkg::NUM_CH - 1)) begin
               state_in = LERP_END;
            end
         end
         LERP_END: begin
            kind_in = 2'd2;
            state_in = FINISH;
         end
         FINISH: begin
            out_load = 1'b1;
            cmd.copy_out = kind_ff == 2'd1;
            cmd.lerp_out = kind_ff == 2'd2;
            state_in = RESPOND;
         end
         RESPOND: begin
            if (rsp_ready) begin
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         status_ff <= klerp_pkg::ST_OK;
         kind_ff <= 2'd0;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         status_ff <= status_in;
         kind_ff <= kind_in;
         step_ff <= step_in;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      ub_ff <= ub_in;
   end

endmodule

// File: rtl/keyframe_lerp_sampler.sv
// Top level of the keyframe lerp sampler: controller, datapath and result register.
// Clear passes through decode and the output load; append adds an order check once
// keys exist. A sample passes through decode, a binary search, the key loads and,
// between two keys, the bit-serial divider and the channel multiplies, then the
// output load. One item is in flight; the next is taken after the result transfer.
// Synchronous reset empties the timeline; keyframe memory is not cleared.
module keyframe_lerp_sampler (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  klerp_pkg::word_type req_time_req,
   input  klerp_pkg::word_type req_pos_x,
   input  klerp_pkg::word_type req_pos_y,
   input  klerp_pkg::word_type req_orientation,
   input  klerp_pkg::word_type req_scale_x,
   input  klerp_pkg::word_type req_scale_y,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output klerp_pkg::word_type rsp_out_pos_x,
   output klerp_pkg::word_type rsp_out_pos_y,
   output klerp_pkg::word_type rsp_out_orientation,
   output klerp_pkg::word_type rsp_out_scale_x,
   output klerp_pkg::word_type rsp_out_scale_y
);

   klerp_pkg::cmd_type cmd;
   klerp_pkg::stat_type stat;
   logic [klerp_pkg::IDX_W-1:0] wr_addr;
   logic out_load;
   klerp_pkg::word_type res_ch [klerp_pkg::NUM_CH];
   klerp_pkg::word_type out_ff [klerp_pkg::NUM_CH];

   klerp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .rsp_status, .cmd, .stat, .wr_addr, .out_load
   );

   klerp_datapath u_dp (
      .clock, .reset, .cmd, .stat, .wr_addr, .req_op, .req_time_req, .req_pos_x,
      .req_pos_y, .req_orientation, .req_scale_x, .req_scale_y, .res_ch
   );

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= res_ch;
      end
   end

   assign rsp_out_pos_x = out_ff[0];
   assign rsp_out_pos_y = out_ff[1];
   assign rsp_out_orientation = out_ff[2];
   assign rsp_out_scale_x = out_ff[3];
   assign rsp_out_scale_y = out_ff[4];

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result sides busy at once");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != klerp_pkg::ST_OK |-> rsp_out_pos_x == '0)
      else $error("error result carries data");
   a_done_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready)
      else $error("not idle after result transfer");

endmodule

// File: verif/keyframe_lerp_sampler_checker.sv
// Checker for the keyframe lerp sampler: predicts each result and compares it.
`timescale 1ns / 100ps
module keyframe_lerp_sampler_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [1:0]          req_op,
   input  klerp_pkg::word_type req_time_req,
   input  klerp_pkg::word_type req_pos_x,
   input  klerp_pkg::word_type req_pos_y,
   input  klerp_pkg::word_type req_orientation,
   input  klerp_pkg::word_type req_scale_x,
   input  klerp_pkg::word_type req_scale_y,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [1:0]          rsp_status,
   input  klerp_pkg::word_type rsp_out_pos_x,
   input  klerp_pkg::word_type rsp_out_pos_y,
   input  klerp_pkg::word_type rsp_out_orientation,
   input  klerp_pkg::word_type rsp_out_scale_x,
   input  klerp_pkg::word_type rsp_out_scale_y,
   output int                  error_count,
   output int                  pending_count
);

   typedef struct packed {
      logic [1:0]          status;
      klerp_pkg::word_type ch0;
      klerp_pkg::word_type ch1;
      klerp_pkg::word_type ch2;
      klerp_pkg::word_type ch3;
      klerp_pkg::word_type ch4;
   } sample_type;

   int                  timeline_len;
   klerp_pkg::word_type stamp_mem [klerp_pkg::DEPTH];
   klerp_pkg::word_type chan_mem [klerp_pkg::DEPTH][klerp_pkg::NUM_CH];
   sample_type          sample_queue[$];

   function automatic klerp_pkg::word_type blend(klerp_pkg::word_type a,
                                                 klerp_pkg::word_type b, longint frac);
      longint prod;
      longint delta;
      begin
         prod = (longint'(b) - longint'(a)) * frac;
         // Arithmetic shift floors toward minus infinity, as required.
         delta = prod >>> 16;
         return klerp_pkg::word_type'(longint'(a) + delta);
      end
   endfunction

   function automatic sample_type predict_sample(klerp_pkg::word_type q);
      sample_type r;
      int upper;
      int lk;
      longint span;
      longint frac;
      klerp_pkg::word_type ch [klerp_pkg::NUM_CH];
      begin
         r = '0;
         upper = 0;
         if (timeline_len == 0) begin
            r.status = klerp_pkg::ST_EMPTY;
            return r;
         end
         while (upper < timeline_len && stamp_mem[upper] <= q) upper++;
         if (upper == 0) lk = 0;
         else lk = upper - 1;
         for (int c = 0; c < klerp_pkg::NUM_CH; c++) ch[c] = chan_mem[lk][c];
         if (upper != 0 && upper != timeline_len) begin
            span = longint'(stamp_mem[upper]) - longint'(stamp_mem[lk]);
            if (span > 0) begin
               frac = ((longint'(q) - longint'(stamp_mem[lk])) <<< 16) / span;
               if (frac > 65535) frac = 65535;
               for (int c = 0; c < klerp_pkg::NUM_CH; c++)
                  ch[c] = blend(chan_mem[lk][c], chan_mem[upper][c], frac);
            end
         end
         r.ch0 = ch[0]; r.ch1 = ch[1]; r.ch2 = ch[2]; r.ch3 = ch[3]; r.ch4 = ch[4];
         return r;
      end
   endfunction

   always @(posedge clock) begin
      sample_type r;
      sample_type got;
      if (reset) begin
         timeline_len = 0;
         sample_queue.delete();
         error_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            r = '0;
            case (req_op)
               klerp_pkg::OP_CLEAR: timeline_len = 0;
               klerp_pkg::OP_APPEND: begin
                  if (timeline_len >= klerp_pkg::DEPTH) begin
                     r.status = klerp_pkg::ST_FULL;
                  end else if (timeline_len > 0
                               && req_time_req < stamp_mem[timeline_len-1]) begin
                     r.status = klerp_pkg::ST_ORDER;
                  end else begin
                     stamp_mem[timeline_len] = req_time_req;
                     chan_mem[timeline_len][0] = req_pos_x;
                     chan_mem[timeline_len][1] = req_pos_y;
                     chan_mem[timeline_len][2] = req_orientation;
                     chan_mem[timeline_len][3] = req_scale_x;
                     chan_mem[timeline_len][4] = req_scale_y;
                     timeline_len = timeline_len + 1;
                  end
               end
               klerp_pkg::OP_SAMPLE: r = predict_sample(req_time_req);
               default: ;
            endcase
            sample_queue.insert(sample_queue.size(), r);
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_out_pos_x, rsp_out_pos_y, rsp_out_orientation,
                   rsp_out_scale_x, rsp_out_scale_y};
            if (sample_queue.size() == 0) begin
               error_count <= error_count + 1;
               if (error_count < 10) $display("Unexpected result transfer: %h", got);
            end else begin
               r = sample_queue.pop_front();
               if (got !== r) begin
                  error_count <= error_count + 1;
                  if (error_count < 10)
                     $display({"Mismatch: expected st=%0d %h %h %h %h %h,",
                               " got st=%0d %h %h %h %h %h"},
                              r.status, r.ch0, r.ch1, r.ch2, r.ch3, r.ch4,
                              got.status, got.ch0, got.ch1, got.ch2, got.ch3, got.ch4);
               end
            end
         end
      end
   end

   assign pending_count = sample_queue.size();

endmodule

// File: verif/keyframe_lerp_sampler_tb.sv
// Testbench top for the keyframe lerp sampler: stimulus, reset, clock and verdict.
`timescale 1ns / 100ps
module keyframe_lerp_sampler_tb;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [1:0]          req_op;
   klerp_pkg::word_type req_time_req, req_pos_x, req_pos_y, req_orientation;
   klerp_pkg::word_type req_scale_x, req_scale_y;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_status;
   klerp_pkg::word_type rsp_out_pos_x, rsp_out_pos_y, rsp_out_orientation;
   klerp_pkg::word_type rsp_out_scale_x, rsp_out_scale_y;
   int                  error_count;
   int                  pending_count;
   int                  cycle_count;
   int                  hold_off;
   bit                  hold_req;
   bit                  calm;
   klerp_pkg::word_type last_stamp;

   keyframe_lerp_sampler i_dut (.*);

   keyframe_lerp_sampler_checker i_checker (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Receiver: random stalls, one long hold-off, a calm stretch without stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_off <= 0;
      end else if (hold_req && hold_off < 300) begin
         hold_off <= hold_off + 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 10);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("keyframe_lerp_sampler test failed");
         $finish;
      end
   end

   task automatic send(logic [1:0] op, klerp_pkg::word_type tq, klerp_pkg::word_type a,
                       klerp_pkg::word_type b, klerp_pkg::word_type c,
                       klerp_pkg::word_type d, klerp_pkg::word_type e);
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_time_req <= tq;
      req_pos_x <= a;
      req_pos_y <= b;
      req_orientation <= c;
      req_scale_x <= d;
      req_scale_y <= e;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic append_random(klerp_pkg::word_type tq);
      send(klerp_pkg::OP_APPEND, tq, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      klerp_pkg::word_type base;
      int n;
      hold_req = 1'b0;
      calm = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_op <= klerp_pkg::OP_CLEAR;
      {req_time_req, req_pos_x, req_pos_y, req_orientation} <= '0;
      {req_scale_x, req_scale_y} <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty timeline, unused op, extremes, order check, equal stamps.
      send(klerp_pkg::OP_SAMPLE, 0, 1, 1, 1, 1, 1);
      send(klerp_pkg::OP_NOP, 5, 5, 5, 5, 5, 5);
      send(klerp_pkg::OP_APPEND, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1);
      send(klerp_pkg::OP_APPEND, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, -1, 0, 7);
      send(klerp_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0);
      send(klerp_pkg::OP_SAMPLE, 32'sh8000_0000, 0, 0, 0, 0, 0);
      send(klerp_pkg::OP_SAMPLE, 32'sh7fff_fffe, 0, 0, 0, 0, 0);
      send(klerp_pkg::OP_SAMPLE, 32'sh7fff_ffff, 0, 0, 0, 0, 0);
      send(klerp_pkg::OP_APPEND, 100, 1, 2, 3, 4, 5);
      send(klerp_pkg::OP_APPEND, 32'sh7fff_ffff, 9, 9, 9, 9, 9);
      send(klerp_pkg::OP_CLEAR, -1, -1, -1, -1, -1, -1);
      send(klerp_pkg::OP_APPEND, 1000, 1, 2, 3, 4, 5);
      send(klerp_pkg::OP_SAMPLE, 999, 0, 0, 0, 0, 0);
      send(klerp_pkg::OP_APPEND, 1000, 7, 7, 7, 7, 7);
      send(klerp_pkg::OP_APPEND, 3000, -100, 100, 65536, -65536, 0);
      send(klerp_pkg::OP_SAMPLE, 1000, 0, 0, 0, 0, 0);
      send(klerp_pkg::OP_SAMPLE, 2000, 0, 0, 0, 0, 0);
      send(klerp_pkg::OP_SAMPLE, 2999, 0, 0, 0, 0, 0);
      // Fill the store to show the full status ahead of the order check.
      for (int i = 3; i < klerp_pkg::DEPTH; i++) append_random(3000 + i);
      send(klerp_pkg::OP_APPEND, 0, 0, 0, 0, 0, 0);
      send(klerp_pkg::OP_SAMPLE, 3040, 0, 0, 0, 0, 0);

      // Long receiver hold-off while items keep coming.
      hold_req = 1'b1;
      for (int i = 0; i < 6; i++) send(klerp_pkg::OP_SAMPLE, $urandom, 0, 0, 0, 0, 0);

      // Random: well-formed timelines with samples, plus some noise.
      n = 0;
      while (n < 700) begin
         if (n > 300 && n < 450) calm = 1'b1;
         else calm = 1'b0;
         send(klerp_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
         n++;
         base = $urandom;
         last_stamp = ($urandom_range(3) == 0) ? base : base >>> $urandom_range(20, 0);
         for (int k = $urandom_range(($urandom_range(9) == 0) ? klerp_pkg::DEPTH + 2 : 8, 1);
              k > 0; k--) begin
            if ($urandom_range(9) == 0) begin
               append_random($urandom);
            end else begin
               if (last_stamp < 32'sh7000_0000)
                  last_stamp = last_stamp + $urandom_range(3) * $urandom_range(65536 * 4);
               append_random(last_stamp);
            end
            n++;
         end
         for (int k = $urandom_range(10, 1); k > 0; k--) begin
            case ($urandom_range(4))
               0: send(klerp_pkg::OP_SAMPLE, $urandom, 0, 0, 0, 0, 0);
               1: send(klerp_pkg::OP_NOP, $urandom, 0, 0, 0, 0, 0);
               default: send(klerp_pkg::OP_SAMPLE, last_stamp - $urandom_range(65536 * 8),
                             $urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            n++;
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("keyframe_lerp_sampler test passed");
      end else begin
         $display("keyframe_lerp_sampler test failed");
      end
      $finish;
   end

endmodule
